### hdl/atab_pkg.sv
// shared types and constants for the associative table
// no dependencies
package atab_pkg;

  localparam int DEPTH       = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW1   = CNT_W + 1;

  localparam logic [1:0] ACT_PUT = 2'd0;
  localparam logic [1:0] ACT_DEL = 2'd1;
  localparam logic [1:0] ACT_GET = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [4:0]  entries_used;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

endpackage

### hdl/assoc_table_insert_remove_lookup.sv
// associative table: linear search over key and value rams, compacting remove
// one item is in flight at a time; the next item is taken once the result is
// registered and the table is idle again. the scan reads one entry per cycle
// from the key/value rams. reset clears the state, the entry count and
// out_valid; rams are not cleared
module assoc_table_insert_remove_lookup (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  atab_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output atab_pkg::out_item_t out_item
);

  atab_pkg::state_t state_r, state_nxt;
  logic [atab_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [atab_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [1:0]                       act_r;
  logic [atab_pkg::KEY_WIDTH-1:0]   key_r;
  logic [atab_pkg::VALUE_WIDTH-1:0] val_r;
  logic                             hit_r, hit_nxt;
  logic [1:0]                       stat_r, stat_nxt;
  logic [atab_pkg::VALUE_WIDTH-1:0] rd_r, rd_nxt;
  logic                             out_valid_r, out_valid_nxt;
  atab_pkg::out_item_t              out_r, out_nxt;

  logic                             rd_en, wr_en;
  logic [atab_pkg::IDX_W-1:0]       rd_addr, wr_addr;
  logic [atab_pkg::KEY_WIDTH-1:0]   key_wdata, key_q;
  logic [atab_pkg::VALUE_WIDTH-1:0] val_wdata, val_q;

  logic [atab_pkg::CW1-1:0] idx_ext, nx1, nx2, cnt_ext;
  logic                     accept, match;

  assign accept  = in_valid && !in_stall;
  assign idx_ext = atab_pkg::CW1'(idx_r);
  assign nx1     = idx_ext + atab_pkg::CW1'(1);
  assign nx2     = idx_ext + atab_pkg::CW1'(2);
  assign cnt_ext = atab_pkg::CW1'(count_r);
  assign match   = (idx_ext < cnt_ext) && (key_q == key_r);

  atab_ram #(
    .WIDTH (atab_pkg::KEY_WIDTH),
    .DEPTH (atab_pkg::DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (key_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (key_q)
  );

  atab_ram #(
    .WIDTH (atab_pkg::VALUE_WIDTH),
    .DEPTH (atab_pkg::DEPTH)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (val_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atab_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    hit_r  <= hit_nxt;
    stat_r <= stat_nxt;
    rd_r   <= rd_nxt;
    out_r  <= out_nxt;
    if (accept) begin
      act_r <= in_item.action;
      key_r <= atab_pkg::KEY_WIDTH'(in_item.key);
      val_r <= atab_pkg::VALUE_WIDTH'(in_item.value);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    hit_nxt       = hit_r;
    stat_nxt      = stat_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    key_wdata     = key_r;
    val_wdata     = val_r;
    in_stall      = (state_r != atab_pkg::S_IDLE);

    unique case (state_r)
      atab_pkg::S_IDLE: begin
        if (in_valid) begin
          hit_nxt  = 1'b0;
          stat_nxt = atab_pkg::STAT_OK;
          rd_nxt   = '0;
          idx_nxt  = '0;
          case (in_item.action) inside
            atab_pkg::ACT_PUT, atab_pkg::ACT_DEL, atab_pkg::ACT_GET: begin
              rd_en     = 1'b1;
              state_nxt = atab_pkg::S_SCAN;
            end
            default: state_nxt = atab_pkg::S_RESP;
          endcase
        end
      end

      atab_pkg::S_SCAN: begin
        if (match) begin
          hit_nxt = 1'b1;
          case (act_r)
            atab_pkg::ACT_PUT: begin
              wr_en     = 1'b1;
              state_nxt = atab_pkg::S_RESP;
            end
            atab_pkg::ACT_GET: begin
              rd_nxt    = val_q;
              state_nxt = atab_pkg::S_RESP;
            end
            default: begin
              if (nx1 < cnt_ext) begin
                rd_en     = 1'b1;
                rd_addr   = atab_pkg::IDX_W'(nx1);
                state_nxt = atab_pkg::S_SHIFT;
              end else begin
                count_nxt = count_r - atab_pkg::CNT_W'(1);
                state_nxt = atab_pkg::S_RESP;
              end
            end
          endcase
        end else if (nx1 < cnt_ext) begin
          rd_en   = 1'b1;
          rd_addr = atab_pkg::IDX_W'(nx1);
          idx_nxt = atab_pkg::IDX_W'(nx1);
        end else begin
          state_nxt = atab_pkg::S_RESP;
          case (act_r)
            atab_pkg::ACT_PUT: begin
              if (count_r < atab_pkg::CNT_W'(atab_pkg::DEPTH)) begin
                wr_en     = 1'b1;
                wr_addr   = atab_pkg::IDX_W'(count_r);
                count_nxt = count_r + atab_pkg::CNT_W'(1);
              end else begin
                stat_nxt = atab_pkg::STAT_FULL;
              end
            end
            default: stat_nxt = atab_pkg::STAT_MISS;
          endcase
        end
      end

      atab_pkg::S_SHIFT: begin
        // move entry idx+1 down into idx
        wr_en     = 1'b1;
        key_wdata = key_q;
        val_wdata = val_q;
        idx_nxt   = atab_pkg::IDX_W'(nx1);
        if (nx2 < cnt_ext) begin
          rd_en   = 1'b1;
          rd_addr = atab_pkg::IDX_W'(nx2);
        end else begin
          count_nxt = count_r - atab_pkg::CNT_W'(1);
          state_nxt = atab_pkg::S_RESP;
        end
      end

      atab_pkg::S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.hit          = hit_r;
          out_nxt.status       = stat_r;
          out_nxt.read_value   = 32'(rd_r);
          out_nxt.entries_used = 5'(count_r);
          state_nxt            = atab_pkg::S_IDLE;
        end
      end

      default: state_nxt = atab_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### hdl/atab_ram.sv
// simple dual-port ram, one write and one registered read port
// no dependencies
module atab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/atab_checker.sv
// port-level checks for the associative table, bound to the top level
// depends on atab_pkg
module atab_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input atab_pkg::out_item_t out_item
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // one item in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while another is in flight");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == atab_pkg::STAT_FULL |->
      !out_item.hit && out_item.entries_used == 5'(atab_pkg::DEPTH))
    else $error("full status with inconsistent table");

  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == atab_pkg::STAT_MISS |->
      !out_item.hit && out_item.read_value == '0)
    else $error("miss status with hit or data");

  a_rdval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.read_value != '0 |->
      out_item.hit && out_item.status == atab_pkg::STAT_OK)
    else $error("read value without a hit");

endmodule

bind assoc_table_insert_remove_lookup atab_checker u_atab_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
